// File: sv/bac_pkg.sv
// ----------------------------------------------------------------------------
// bac_pkg: shared types and constants of the BSC/AWGN channel emulator
// Sequencer step codes, controller/datapath command and status words,
// register indexes, fixed-point constants and divide-by-constant tables.
// ----------------------------------------------------------------------------
package bac_pkg;

	// output and noise formats
	localparam int LLR_WIDTH       = 16;
	localparam int NOISE_FRAC_BITS = 11;
	// magnitude of the Gaussian sample: four integer bits plus guard
	localparam int GMAG_W          = 5 + NOISE_FRAC_BITS;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SIGMA    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LLR_SCALE      = 3'd4;

	// register reset values
	localparam logic [31:0] SEED_RESET  = 32'd2463534242;
	localparam logic [15:0] SIGMA_RESET = 16'd4096;
	localparam logic [15:0] SCALE_RESET = 16'd512;

	// 2*ln(2) in Q.26 and pi/2 in Q.30
	localparam logic [31:0] TWO_LN2_Q26 = 32'd93032640;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	// loop counter
	localparam int IDX_W = 5;
	localparam logic [IDX_W-1:0] LOOP_LAST = 5'd31;  // 32-step loops
	localparam logic [IDX_W-1:0] SER_LAST  = 5'd6;   // seven series terms

	// exact n/d for n < 2^30: (n * RECIP) >> SHIFT, RECIP = 2^SHIFT/d + 1
	localparam logic [30:0] CT_RECIP [7] = '{
		31'((64'd1 << 31) / 64'd2   + 64'd1),
		31'((64'd1 << 34) / 64'd12  + 64'd1),
		31'((64'd1 << 35) / 64'd30  + 64'd1),
		31'((64'd1 << 36) / 64'd56  + 64'd1),
		31'((64'd1 << 37) / 64'd90  + 64'd1),
		31'((64'd1 << 38) / 64'd132 + 64'd1),
		31'((64'd1 << 38) / 64'd182 + 64'd1)
	};
	localparam logic [5:0] CT_SHIFT [7] = '{6'd31, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd38};

	localparam logic [30:0] ST_RECIP [7] = '{
		31'((64'd1 << 33) / 64'd6   + 64'd1),
		31'((64'd1 << 35) / 64'd20  + 64'd1),
		31'((64'd1 << 36) / 64'd42  + 64'd1),
		31'((64'd1 << 37) / 64'd72  + 64'd1),
		31'((64'd1 << 37) / 64'd110 + 64'd1),
		31'((64'd1 << 38) / 64'd156 + 64'd1),
		31'((64'd1 << 38) / 64'd210 + 64'd1)
	};
	localparam logic [5:0] ST_SHIFT [7] = '{6'd33, 6'd35, 6'd36, 6'd37, 6'd37, 6'd38, 6'd38};

	// sequencer steps; the controller state and the datapath command share them
	typedef enum logic [5:0] {
		STEP_IDLE,
		STEP_BSC,
		STEP_DRAW1,
		STEP_DRAW2,
		STEP_NORM,
		STEP_LOG_MUL,
		STEP_LOG_WB,
		STEP_T_FORM,
		STEP_TL_MUL,
		STEP_TL_WB,
		STEP_TH_MUL,
		STEP_TH_WB,
		STEP_SQRT,
		STEP_PHI_MUL,
		STEP_PHI_WB,
		STEP_PHI2_MUL,
		STEP_PHI2_WB,
		STEP_CT_MUL,
		STEP_CT_WB,
		STEP_CTD_MUL,
		STEP_CTD_WB,
		STEP_ST_MUL,
		STEP_ST_WB,
		STEP_STD_MUL,
		STEP_STD_WB,
		STEP_COS_SEL,
		STEP_G_MUL,
		STEP_G_WB,
		STEP_Y_MUL,
		STEP_Y_WB,
		STEP_L_MUL,
		STEP_L_WB,
		STEP_DONE
	} bac_step_t;

	typedef struct packed {
		bac_step_t        step;
		logic [IDX_W-1:0] idx;
		logic             load;   // take the input word
		logic             push;   // move the result to the output register
	} bac_cmd_t;

	typedef struct packed {
		logic mode;        // 1: AWGN
		logic norm_done;   // log mantissa normalized
	} bac_stat_t;

endpackage

// File: sv/bac_ifs.sv
// ----------------------------------------------------------------------------
// bac_ifs: stream channels of the channel emulator
// Code-bit input channel and received-word output channel, valid/ready.
// ----------------------------------------------------------------------------
interface bac_bit_if;
	logic valid;
	logic ready;
	logic bit_in;
	logic last_bit;

	modport source (output valid, output bit_in, output last_bit, input ready);
	modport sink (input valid, input bit_in, input last_bit, output ready);
endinterface

interface bac_llr_if;
	logic                                      valid;
	logic                                      ready;
	logic                                      bit_out;
	logic signed [bac_pkg::LLR_WIDTH-1:0]      llr;
	logic                                      last_out;

	modport source (output valid, output bit_out, output llr, output last_out, input ready);
	modport sink (input valid, input bit_out, input llr, input last_out, output ready);
endinterface

// File: sv/bac_ctrl.sv
// ----------------------------------------------------------------------------
// bac_ctrl: sequencer of the channel emulator
// Walks each AWGN word through draw, log, root, cosine and LLR steps and each
// BSC word through the BSC step, and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module bac_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  bac_pkg::bac_stat_t  stat,
	output bac_pkg::bac_cmd_t   cmd
);

	bac_pkg::bac_step_t            state_q, state_nxt;
	logic [bac_pkg::IDX_W-1:0]     idx_q, idx_nxt;
	logic                          out_valid_q;
	logic                          slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == bac_pkg::STEP_IDLE);
	assign out_valid = out_valid_q;

	// state and counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bac_pkg::STEP_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			idx_q   <= idx_nxt;
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		idx_nxt   = idx_q;
		cmd.step  = state_q;
		cmd.idx   = idx_q;
		cmd.load  = 1'b0;
		cmd.push  = 1'b0;
		case (state_q)
			bac_pkg::STEP_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = stat.mode ? bac_pkg::STEP_DRAW1 : bac_pkg::STEP_BSC;
				end
			end
			bac_pkg::STEP_BSC:   state_nxt = bac_pkg::STEP_DONE;
			bac_pkg::STEP_DRAW1: state_nxt = bac_pkg::STEP_DRAW2;
			bac_pkg::STEP_DRAW2: state_nxt = bac_pkg::STEP_NORM;
			bac_pkg::STEP_NORM: begin
				if (stat.norm_done) begin
					idx_nxt   = '0;
					state_nxt = bac_pkg::STEP_LOG_MUL;
				end
			end
			bac_pkg::STEP_LOG_MUL: state_nxt = bac_pkg::STEP_LOG_WB;
			bac_pkg::STEP_LOG_WB: begin
				idx_nxt = idx_q + 1'b1;
				state_nxt = (idx_q == bac_pkg::LOOP_LAST) ? bac_pkg::STEP_T_FORM
				                                          : bac_pkg::STEP_LOG_MUL;
			end
			bac_pkg::STEP_T_FORM: state_nxt = bac_pkg::STEP_TL_MUL;
			bac_pkg::STEP_TL_MUL: state_nxt = bac_pkg::STEP_TL_WB;
			bac_pkg::STEP_TL_WB:  state_nxt = bac_pkg::STEP_TH_MUL;
			bac_pkg::STEP_TH_MUL: state_nxt = bac_pkg::STEP_TH_WB;
			bac_pkg::STEP_TH_WB: begin
				idx_nxt   = '0;
				state_nxt = bac_pkg::STEP_SQRT;
			end
			bac_pkg::STEP_SQRT: begin
				idx_nxt = idx_q + 1'b1;
				if (idx_q == bac_pkg::LOOP_LAST)
					state_nxt = bac_pkg::STEP_PHI_MUL;
			end
			bac_pkg::STEP_PHI_MUL:  state_nxt = bac_pkg::STEP_PHI_WB;
			bac_pkg::STEP_PHI_WB:   state_nxt = bac_pkg::STEP_PHI2_MUL;
			bac_pkg::STEP_PHI2_MUL: state_nxt = bac_pkg::STEP_PHI2_WB;
			bac_pkg::STEP_PHI2_WB: begin
				idx_nxt   = '0;
				state_nxt = bac_pkg::STEP_CT_MUL;
			end
			bac_pkg::STEP_CT_MUL:  state_nxt = bac_pkg::STEP_CT_WB;
			bac_pkg::STEP_CT_WB:   state_nxt = bac_pkg::STEP_CTD_MUL;
			bac_pkg::STEP_CTD_MUL: state_nxt = bac_pkg::STEP_CTD_WB;
			bac_pkg::STEP_CTD_WB:  state_nxt = bac_pkg::STEP_ST_MUL;
			bac_pkg::STEP_ST_MUL:  state_nxt = bac_pkg::STEP_ST_WB;
			bac_pkg::STEP_ST_WB:   state_nxt = bac_pkg::STEP_STD_MUL;
			bac_pkg::STEP_STD_MUL: state_nxt = bac_pkg::STEP_STD_WB;
			bac_pkg::STEP_STD_WB: begin
				if (idx_q == bac_pkg::SER_LAST) begin
					state_nxt = bac_pkg::STEP_COS_SEL;
				end else begin
					idx_nxt   = idx_q + 1'b1;
					state_nxt = bac_pkg::STEP_CT_MUL;
				end
			end
			bac_pkg::STEP_COS_SEL: state_nxt = bac_pkg::STEP_G_MUL;
			bac_pkg::STEP_G_MUL:   state_nxt = bac_pkg::STEP_G_WB;
			bac_pkg::STEP_G_WB:    state_nxt = bac_pkg::STEP_Y_MUL;
			bac_pkg::STEP_Y_MUL:   state_nxt = bac_pkg::STEP_Y_WB;
			bac_pkg::STEP_Y_WB:    state_nxt = bac_pkg::STEP_L_MUL;
			bac_pkg::STEP_L_MUL:   state_nxt = bac_pkg::STEP_L_WB;
			bac_pkg::STEP_L_WB:    state_nxt = bac_pkg::STEP_DONE;
			bac_pkg::STEP_DONE: begin
				if (slot_free) begin
					cmd.push  = 1'b1;
					state_nxt = bac_pkg::STEP_IDLE;
				end
			end
			default: state_nxt = bac_pkg::STEP_IDLE;
		endcase
	end

endmodule

// File: sv/bac_dp.sv
// ----------------------------------------------------------------------------
// bac_dp: datapath of the channel emulator
// Configuration registers, xorshift generator, one shared 32x32 multiplier
// with registered product, log/root/cosine working registers, result and
// output registers.
// ----------------------------------------------------------------------------
module bac_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [bac_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  logic [bac_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	input  bac_pkg::bac_cmd_t                      cmd,
	output bac_pkg::bac_stat_t                     stat,
	input  logic                                   bit_in,
	input  logic                                   last_bit,
	output logic                                   bit_out,
	output logic signed [bac_pkg::LLR_WIDTH-1:0]   llr,
	output logic                                   last_out
);

	localparam int W  = bac_pkg::LLR_WIDTH;
	localparam int NF = bac_pkg::NOISE_FRAC_BITS;

	function automatic logic [31:0] xs_next(input logic [31:0] s);
		logic [31:0] x;
		x = s ^ (s << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

	// configuration and generator state
	logic        mode_q;
	logic [31:0] thr_q;
	logic [15:0] sigma_q;
	logic [15:0] scale_q;
	logic [31:0] rng_q;
	logic [31:0] rng_nxt;
	logic        draw;

	// item and working registers
	logic                      bit_q, last_q;
	logic [31:0]               m_q, f_q;
	logic [4:0]                sh_q;
	logic [37:0]               t_q;
	logic [63:0]               acc_q, v_q, r_q;
	logic [1:0]                quad_q;
	logic                      rem_neg_q;
	logic [29:0]               ar_q, phi_q, phi2_q, tmp_q, st_q;
	logic [30:0]               ct_q;
	logic signed [31:0]        cs_q, sn_q;
	logic                      c_neg_q;
	logic [30:0]               c_abs_q;
	logic                      g_neg_q;
	logic [bac_pkg::GMAG_W-1:0] g_mag_q;
	logic                      y_neg_q;
	logic [31:0]               y_abs_q;
	logic                      res_bit_q;
	logic [W-1:0]              res_llr_q;
	logic                      out_bit_q, out_last_q;
	logic [W-1:0]              out_llr_q;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;

	// combinational helpers
	logic [31:0]        b2;
	logic [63:0]        sq_bit, sq_sum, th_sum, g_rnd, l_rnd, l_sat;
	logic [29:0]        ct_div, st_div;
	logic signed [31:0] sn_f, c_val;
	logic signed [33:0] y_one, y_noise, y_val;
	logic [33:0]        y_mag;
	logic [W-1:0]       l_val;
	logic [2:0]         sidx;

	assign sidx    = cmd.idx[2:0];
	assign rng_nxt = xs_next(rng_q);
	assign draw    = (cmd.step == bac_pkg::STEP_BSC) || (cmd.step == bac_pkg::STEP_DRAW1)
	              || (cmd.step == bac_pkg::STEP_DRAW2);

	assign stat.mode      = mode_q;
	assign stat.norm_done = m_q[31];

	assign bit_out  = out_bit_q;
	assign llr      = signed'(out_llr_q);
	assign last_out = out_last_q;

	// configuration registers and generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			thr_q   <= '0;
			sigma_q <= bac_pkg::SIGMA_RESET;
			scale_q <= bac_pkg::SCALE_RESET;
			rng_q   <= bac_pkg::SEED_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					bac_pkg::REG_CHANNEL_MODE:   mode_q  <= cfg_wdata[0];
					bac_pkg::REG_FLIP_THRESHOLD: thr_q   <= cfg_wdata;
					bac_pkg::REG_NOISE_SIGMA:    sigma_q <= cfg_wdata[15:0];
					bac_pkg::REG_LLR_SCALE:      scale_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (cfg_we && cfg_idx == bac_pkg::REG_RNG_SEED)
				rng_q <= cfg_wdata;
			else if (draw)
				rng_q <= rng_nxt;
		end
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.step)
			bac_pkg::STEP_LOG_MUL: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			bac_pkg::STEP_TL_MUL: begin
				mul_a = t_q[31:0];
				mul_b = bac_pkg::TWO_LN2_Q26;
			end
			bac_pkg::STEP_TH_MUL: begin
				mul_a = {26'd0, t_q[37:32]};
				mul_b = bac_pkg::TWO_LN2_Q26;
			end
			bac_pkg::STEP_PHI_MUL: begin
				mul_a = {2'd0, ar_q};
				mul_b = bac_pkg::HALF_PI_Q30;
			end
			bac_pkg::STEP_PHI2_MUL: begin
				mul_a = {2'd0, phi_q};
				mul_b = {2'd0, phi_q};
			end
			bac_pkg::STEP_CT_MUL: begin
				mul_a = {1'b0, ct_q};
				mul_b = {2'd0, phi2_q};
			end
			bac_pkg::STEP_CTD_MUL: begin
				mul_a = {2'd0, tmp_q};
				mul_b = {1'b0, bac_pkg::CT_RECIP[sidx]};
			end
			bac_pkg::STEP_ST_MUL: begin
				mul_a = {2'd0, st_q};
				mul_b = {2'd0, phi2_q};
			end
			bac_pkg::STEP_STD_MUL: begin
				mul_a = {2'd0, tmp_q};
				mul_b = {1'b0, bac_pkg::ST_RECIP[sidx]};
			end
			bac_pkg::STEP_G_MUL: begin
				mul_a = r_q[31:0];
				mul_b = {1'b0, c_abs_q};
			end
			bac_pkg::STEP_Y_MUL: begin
				mul_a = 32'(g_mag_q);
				mul_b = {16'd0, sigma_q};
			end
			bac_pkg::STEP_L_MUL: begin
				mul_a = y_abs_q;
				mul_b = {16'd0, scale_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk)
		prod_q <= 64'(mul_a) * 64'(mul_b);

	// step arithmetic
	always_comb begin
		// second draw: shift phase by an eighth turn, split off the quadrant
		b2      = rng_nxt + 32'h2000_0000;
		// root step
		sq_bit  = 64'd1 << (6'd62 - {cmd.idx, 1'b0});
		sq_sum  = r_q + sq_bit;
		th_sum  = acc_q + {prod_q[31:0], 32'd0};
		// series terms
		ct_div  = 30'(prod_q >> bac_pkg::CT_SHIFT[sidx]);
		st_div  = 30'(prod_q >> bac_pkg::ST_SHIFT[sidx]);
		// quadrant select
		sn_f    = rem_neg_q ? -sn_q : sn_q;
		case (quad_q)
			2'd0:    c_val = cs_q;
			2'd1:    c_val = -sn_f;
			2'd2:    c_val = -cs_q;
			default: c_val = sn_f;
		endcase
		// sample rounding, ties away from zero on the magnitude
		g_rnd   = (prod_q + (64'd1 << (57 - NF))) >> (58 - NF);
		// received value
		y_one   = 34'sd1 <<< (12 + NF);
		y_noise = signed'({2'd0, prod_q[31:0]});
		y_val   = (bit_q ? -y_one : y_one) + (g_neg_q ? -y_noise : y_noise);
		y_mag   = y_val[33] ? 34'(-y_val) : 34'(y_val);
		// LLR rounding and saturation
		l_rnd   = (prod_q + (64'd1 << (11 + NF))) >> (12 + NF);
		if (y_neg_q)
			l_sat = (l_rnd > (64'd1 << (W - 1))) ? (64'd1 << (W - 1)) : l_rnd;
		else
			l_sat = (l_rnd > ((64'd1 << (W - 1)) - 64'd1)) ? ((64'd1 << (W - 1)) - 64'd1)
			                                                : l_rnd;
		l_val   = y_neg_q ? W'(-l_sat) : W'(l_sat);
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bit_q  <= bit_in;
			last_q <= last_bit;
		end
		case (cmd.step)
			bac_pkg::STEP_BSC: begin
				res_bit_q <= bit_q ^ (rng_nxt < thr_q);
				res_llr_q <= '0;
			end
			bac_pkg::STEP_DRAW1: begin
				// a zero draw counts as one LSB
				m_q  <= (rng_nxt == 32'd0) ? 32'd1 : rng_nxt;
				sh_q <= '0;
				f_q  <= '0;
			end
			bac_pkg::STEP_DRAW2: begin
				quad_q    <= b2[31:30];
				rem_neg_q <= ~b2[29];
				ar_q      <= b2[29] ? {1'b0, b2[28:0]} : 30'h2000_0000 - {1'b0, b2[28:0]};
			end
			bac_pkg::STEP_NORM: begin
				if (!m_q[31]) begin
					m_q  <= m_q << 1;
					sh_q <= sh_q + 1'b1;
				end
			end
			bac_pkg::STEP_LOG_WB: begin
				// square the mantissa, one fraction bit of the log per pass
				if (prod_q[63]) begin
					f_q <= {f_q[30:0], 1'b1};
					m_q <= prod_q[63:32];
				end else begin
					f_q <= {f_q[30:0], 1'b0};
					m_q <= prod_q[62:31];
				end
			end
			bac_pkg::STEP_T_FORM: t_q <= {6'({1'b0, sh_q}) + 6'd1, 32'd0} - {6'd0, f_q};
			bac_pkg::STEP_TL_WB:  acc_q <= prod_q;
			bac_pkg::STEP_TH_WB: begin
				v_q <= {2'd0, th_sum[63:2]};
				r_q <= '0;
			end
			bac_pkg::STEP_SQRT: begin
				if (v_q >= sq_sum) begin
					v_q <= v_q - sq_sum;
					r_q <= (r_q >> 1) + sq_bit;
				end else begin
					r_q <= r_q >> 1;
				end
			end
			bac_pkg::STEP_PHI_WB: phi_q <= prod_q[59:30];
			bac_pkg::STEP_PHI2_WB: begin
				phi2_q <= prod_q[59:30];
				ct_q   <= 31'h4000_0000;
				st_q   <= phi_q;
				cs_q   <= 32'sh4000_0000;
				sn_q   <= signed'({2'd0, phi_q});
			end
			bac_pkg::STEP_CT_WB, bac_pkg::STEP_ST_WB: tmp_q <= prod_q[59:30];
			bac_pkg::STEP_CTD_WB: begin
				ct_q <= {1'b0, ct_div};
				if (!sidx[0])
					cs_q <= cs_q - signed'({2'd0, ct_div});
				else
					cs_q <= cs_q + signed'({2'd0, ct_div});
			end
			bac_pkg::STEP_STD_WB: begin
				st_q <= st_div;
				if (!sidx[0])
					sn_q <= sn_q - signed'({2'd0, st_div});
				else
					sn_q <= sn_q + signed'({2'd0, st_div});
			end
			bac_pkg::STEP_COS_SEL: begin
				c_neg_q <= c_val[31];
				c_abs_q <= c_val[31] ? 31'(-c_val) : 31'(c_val);
			end
			bac_pkg::STEP_G_WB: begin
				g_mag_q <= g_rnd[bac_pkg::GMAG_W-1:0];
				g_neg_q <= c_neg_q;
			end
			bac_pkg::STEP_Y_WB: begin
				y_neg_q <= y_val[33];
				y_abs_q <= y_mag[31:0];
			end
			bac_pkg::STEP_L_WB: begin
				res_llr_q <= l_val;
				res_bit_q <= l_val[W-1];
			end
			default: ;
		endcase
		// output register
		if (cmd.push) begin
			out_bit_q  <= res_bit_q;
			out_llr_q  <= res_llr_q;
			out_last_q <= last_q;
		end
	end

endmodule

// File: sv/bsc_awgn_channel_emulator_unit.sv
// ----------------------------------------------------------------------------
// bsc_awgn_channel_emulator_unit: BSC / AWGN channel emulator
// Passes each code bit through a binary symmetric channel or a BPSK
// Box-Muller AWGN channel driven by a 32-bit xorshift generator.
//
//   channel  | dir | payload                   | word
//   ---------+-----+---------------------------+-----------------------------
//   bit_ch   | in  | bit_in, last_bit          | one transmitted code bit
//   llr_ch   | out | bit_out, llr, last_out    | one received bit and its LLR
//   cfg      | in  | cfg_we, cfg_idx, cfg_wdata | one register write
//
// BSC words pass through the BSC and done steps from accept to output valid.
// AWGN words take up to 31 normalization shifts and 32 root steps, plus 32
// squaring passes of the log and 28 series products, all through one shared
// 32x32 multiplier. One word is in work at a time; a new word is accepted
// while the previous result waits in the output register. Reset loads the
// seed reset value into the generator; there is no clearing pass.
// ----------------------------------------------------------------------------
module bsc_awgn_channel_emulator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	bac_bit_if.sink                         bit_ch,
	bac_llr_if.source                       llr_ch,
	input  logic                            cfg_we,
	input  logic [bac_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	bac_pkg::bac_cmd_t  cmd;
	bac_pkg::bac_stat_t stat;

	// sequencer
	bac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bit_ch.valid),
		.in_ready  (bit_ch.ready),
		.out_valid (llr_ch.valid),
		.out_ready (llr_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic and registers
	bac_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.bit_in    (bit_ch.bit_in),
		.last_bit  (bit_ch.last_bit),
		.bit_out   (llr_ch.bit_out),
		.llr       (llr_ch.llr),
		.last_out  (llr_ch.last_out)
	);

	// one word in work at a time
	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		bit_ch.valid && bit_ch.ready |=> !bit_ch.ready)
		else $error("input accepted on two cycles in a row");

	// a negative LLR always decides a one
	a_llr_sign: assert property (@(posedge clk) disable iff (!arst_n)
		llr_ch.valid && llr_ch.llr[bac_pkg::LLR_WIDTH-1] |-> llr_ch.bit_out)
		else $error("negative LLR with received bit zero");

	// output valid only rises after a result push
	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(llr_ch.valid) |-> $past(cmd.push))
		else $error("output valid without a result push");

endmodule

// File: tb/sv/bac_tb_ifs.sv
// ----------------------------------------------------------------------------
// bac_tb_ifs: testbench-side word type of the channel emulator
// One received word as the scoreboard holds and compares it.
// ----------------------------------------------------------------------------
package bac_tb_pkg;

	typedef struct packed {
		logic                                 bit_out;
		logic signed [bac_pkg::LLR_WIDTH-1:0] llr;
		logic                                 last_out;
	} rx_word_t;

endpackage

// File: tb/sv/bsc_awgn_channel_emulator_unit_tb.sv
// ----------------------------------------------------------------------------
// bsc_awgn_channel_emulator_unit_tb: self-checking bench of the channel emulator
// Runs a directed table, then random words over several register settings in
// both channel modes. Every accepted code bit is predicted by a bit-exact model
// of the xorshift, Box-Muller and LLR arithmetic, or by its typed row, and
// compared in order with the received words. The sender bursts, the receiver
// stalls, and once it holds off long enough for the block to back up onto its input.
// ----------------------------------------------------------------------------
module bsc_awgn_channel_emulator_unit_tb;
	import bac_pkg::*;
	import bac_tb_pkg::*;

	localparam int LLR_MAX = (1 << (LLR_WIDTH - 1)) - 1;
	localparam int N_PHASES = 8;
	localparam int PHASE_WORDS = 125;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bac_bit_if bit_ch();
	bac_llr_if llr_ch();

	bsc_awgn_channel_emulator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.bit_ch(bit_ch),
		.llr_ch(llr_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// register settings
	typedef struct {
		logic        mode;
		logic [31:0] seed;
		logic [31:0] thresh;
		logic [15:0] sigma;
		logic [15:0] scale;
	} chan_cfg_t;

	// directed rows; typed rows carry an expectation read straight off the spec
	typedef struct {
		int   cfg_sel;
		logic b;
		logic l;
		logic typed;
		logic exp_b;
		int   exp_llr;
	} dir_row_t;

	chan_cfg_t dir_cfgs [8] = '{
		'{1'b0, SEED_RESET, 32'd0, SIGMA_RESET, SCALE_RESET},
		'{1'b0, 32'd0, 32'hFFFF_FFFF, SIGMA_RESET, SCALE_RESET},
		'{1'b0, 32'd1, 32'h8000_0000, SIGMA_RESET, SCALE_RESET},
		'{1'b1, 32'd0, 32'd0, 16'd0, 16'd512},
		'{1'b1, 32'd0, 32'd0, 16'd0, 16'hFFFF},
		'{1'b1, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF},
		'{1'b1, 32'hFFFF_FFFF, 32'd0, 16'd4096, 16'd512},
		'{1'b1, 32'd12345, 32'd0, 16'd4096, 16'd0}
	};

	dir_row_t dir_rows [23] = '{
		// reset settings: BSC, threshold zero, bit passes
		'{0, 1'b0, 1'b0, 1'b1, 1'b0, 0},
		'{0, 1'b1, 1'b1, 1'b1, 1'b1, 0},
		'{0, 1'b1, 1'b0, 1'b1, 1'b1, 0},
		// zero seed, full threshold: every draw is 0, always flips
		'{1, 1'b0, 1'b0, 1'b1, 1'b1, 0},
		'{1, 1'b1, 1'b1, 1'b1, 1'b0, 0},
		'{1, 1'b0, 1'b1, 1'b1, 1'b1, 0},
		'{2, 1'b0, 1'b0, 1'b0, 1'b0, 0},
		'{2, 1'b1, 1'b0, 1'b0, 1'b0, 0},
		'{2, 1'b0, 1'b1, 1'b0, 1'b0, 0},
		'{2, 1'b1, 1'b1, 1'b0, 1'b0, 0},
		// no noise: llr is the bare BPSK symbol times the scale
		'{3, 1'b0, 1'b0, 1'b1, 1'b0, 512},
		'{3, 1'b1, 1'b1, 1'b1, 1'b1, -512},
		'{4, 1'b0, 1'b0, 1'b1, 1'b0, LLR_MAX},
		'{4, 1'b1, 1'b1, 1'b1, 1'b1, -LLR_MAX - 1},
		// zero first draw clamped, largest sigma and scale
		'{5, 1'b0, 1'b0, 1'b0, 1'b0, 0},
		'{5, 1'b1, 1'b1, 1'b0, 1'b0, 0},
		'{6, 1'b0, 1'b0, 1'b0, 1'b0, 0},
		'{6, 1'b1, 1'b0, 1'b0, 1'b0, 0},
		'{6, 1'b0, 1'b1, 1'b0, 1'b0, 0},
		'{6, 1'b1, 1'b1, 1'b0, 1'b0, 0},
		'{7, 1'b1, 1'b0, 1'b0, 1'b0, 0},
		// zero scale gives zero llr
		'{7, 1'b0, 1'b1, 1'b1, 1'b0, 0},
		'{7, 1'b1, 1'b1, 1'b1, 1'b0, 0}
	};

	// channel model state
	chan_cfg_t   cur_cfg;
	logic [31:0] rng_q;

	rx_word_t rx_expected [$];
	int       err_cnt;
	int       burst_left;
	int       hold_req;
	int       hold_served;

	// clock and reset
	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// xorshift 13/17/5, one draw
	function automatic logic [31:0] rng_draw();
		logic [31:0] x;
		x = rng_q;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		rng_q = x;
		return x;
	endfunction

	// -log2(x / 2^32), 32 fraction bits, by repeated squaring
	function automatic logic [63:0] neg_log2(input logic [31:0] x);
		int          e;
		logic [63:0] m;
		logic [63:0] f;
		e = 31;
		f = 64'd0;
		while (e > 0 && x[e] == 1'b0)
			e--;
		m = 64'(x) << (31 - e);
		for (int i = 0; i < 32; i++) begin
			m = m * m;
			f = f << 1;
			if (m[63]) begin
				f[0] = 1'b1;
				m = m >> 32;
			end else begin
				m = m >> 31;
			end
		end
		return (64'(32 - e) << 32) - f;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 64'd0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// cos(2 pi turns / 2^32) in Q.30: octant fold, then Taylor series
	function automatic longint cos_turns(input logic [31:0] turns);
		logic [31:0] b;
		logic [1:0]  q;
		longint      rem, ar, phi, phi2, cs, ct, sn, st;
		b = turns + 32'h2000_0000;
		q = b[31:30];
		rem = longint'({34'd0, b[29:0]}) - (64'sd1 <<< 29);
		ar = (rem < 0) ? -rem : rem;
		phi = (ar * longint'({32'd0, HALF_PI_Q30})) >>> 30;
		phi2 = (phi * phi) >>> 30;
		cs = 64'sd1 <<< 30;
		ct = cs;
		sn = phi;
		st = phi;
		for (longint k = 1; k <= 7; k++) begin
			ct = ((ct * phi2) >>> 30) / ((2 * k - 1) * (2 * k));
			st = ((st * phi2) >>> 30) / ((2 * k) * (2 * k + 1));
			if (k[0]) begin
				cs -= ct;
				sn -= st;
			end else begin
				cs += ct;
				sn += st;
			end
		end
		if (rem < 0)
			sn = -sn;
		case (q)
			2'd0: return cs;
			2'd1: return -sn;
			2'd2: return -cs;
			default: return sn;
		endcase
	endfunction

	// Box-Muller cosine sample, signed Q4.NOISE_FRAC_BITS
	function automatic longint gauss_noise(input logic [31:0] x1, input logic [31:0] x2);
		logic [63:0] t;
		logic [63:0] r;
		logic [63:0] mag;
		longint      c;
		t = neg_log2((x1 == 32'd0) ? 32'd1 : x1);
		r = int_sqrt((t * 64'(TWO_LN2_Q26)) >> 2);
		c = cos_turns(x2);
		mag = r * 64'((c < 0) ? -c : c);
		mag = (mag + (64'd1 << (57 - NOISE_FRAC_BITS))) >> (58 - NOISE_FRAC_BITS);
		return (c < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	// received word for one transmitted bit; advances the generator
	function automatic rx_word_t channel_out(input logic b, input logic l);
		rx_word_t    w;
		logic [31:0] x1;
		logic [31:0] x2;
		longint      g, y, raw, mag, one;
		w.last_out = l;
		w.llr = '0;
		if (!cur_cfg.mode) begin
			x1 = rng_draw();
			w.bit_out = (x1 < cur_cfg.thresh) ? ~b : b;
		end else begin
			x1 = rng_draw();
			x2 = rng_draw();
			g = gauss_noise(x1, x2);
			one = 64'sd1 <<< (12 + NOISE_FRAC_BITS);
			y = (b ? -one : one) + longint'({48'd0, cur_cfg.sigma}) * g;
			raw = y * longint'({48'd0, cur_cfg.scale});
			mag = (raw < 0) ? -raw : raw;
			mag = (mag + (64'sd1 <<< (11 + NOISE_FRAC_BITS))) >>> (12 + NOISE_FRAC_BITS);
			if (raw < 0) begin
				if (mag > LLR_MAX + 1)
					mag = LLR_MAX + 1;
				w.llr = LLR_WIDTH'(-mag);
			end else begin
				if (mag > LLR_MAX)
					mag = LLR_MAX;
				w.llr = LLR_WIDTH'(mag);
			end
			w.bit_out = w.llr < 0;
		end
		return w;
	endfunction

	// wait until the block is empty, then write all five registers
	task automatic load_cfg(input chan_cfg_t c);
		bit_ch.valid <= 1'b0;
		while (rx_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_CHANNEL_MODE;
		cfg_wdata <= 32'(c.mode);
		@(posedge clk);
		cfg_idx <= REG_RNG_SEED;
		cfg_wdata <= c.seed;
		@(posedge clk);
		cfg_idx <= REG_FLIP_THRESHOLD;
		cfg_wdata <= c.thresh;
		@(posedge clk);
		cfg_idx <= REG_NOISE_SIGMA;
		cfg_wdata <= 32'(c.sigma);
		@(posedge clk);
		cfg_idx <= REG_LLR_SCALE;
		cfg_wdata <= 32'(c.scale);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_cfg = c;
		rng_q = c.seed;
	endtask

	// offer one code bit in bursts; predict it once accepted
	task automatic send_word(input logic b, input logic l, input logic typed,
			input logic exp_b, input int exp_llr);
		rx_word_t w;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				bit_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		bit_ch.valid <= 1'b1;
		bit_ch.bit_in <= b;
		bit_ch.last_bit <= l;
		do @(posedge clk); while (!bit_ch.ready);
		w = channel_out(b, l);
		if (typed) begin
			w.bit_out = exp_b;
			w.llr = LLR_WIDTH'(exp_llr);
		end
		rx_expected.push_back(w);
	endtask

	// stimulus
	initial begin
		chan_cfg_t rc;
		bit_ch.valid = 1'b0;
		bit_ch.bit_in = 1'b0;
		bit_ch.last_bit = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_CHANNEL_MODE;
		cfg_wdata = '0;
		err_cnt = 0;
		burst_left = 0;
		hold_req = 0;
		cur_cfg = dir_cfgs[0];
		rng_q = SEED_RESET;
		@(posedge arst_n);
		@(posedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			if (i > 0 && dir_rows[i].cfg_sel != dir_rows[i - 1].cfg_sel)
				load_cfg(dir_cfgs[dir_rows[i].cfg_sel]);
			send_word(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed,
				dir_rows[i].exp_b, dir_rows[i].exp_llr);
		end

		// random phases; the first is BSC with a long receiver hold-off
		for (int p = 0; p < N_PHASES; p++) begin
			rc.mode = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
			rc.seed = $urandom_range(1, 32'hFFFF_FFFF);
			case ($urandom_range(0, 3))
				0: rc.thresh = 32'd0;
				1: rc.thresh = 32'h8000_0000;
				2: rc.thresh = 32'hFFFF_FFFF;
				default: rc.thresh = $urandom_range(0, 32'h8000_0000);
			endcase
			case ($urandom_range(0, 2))
				0: rc.sigma = 16'hFFFF;
				1: rc.sigma = 16'($urandom_range(1, 8192));
				default: rc.sigma = 16'($urandom_range(1, 65535));
			endcase
			rc.scale = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
			load_cfg(rc);
			if (p == 0)
				hold_req++;
			for (int n = 0; n < PHASE_WORDS; n++)
				send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, 1'b0, 0);
		end
		bit_ch.valid <= 1'b0;

		// drain
		while (rx_expected.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
		if (err_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: shifting stall pattern, plus a long hold-off on request
	initial begin
		int rx_style;
		rx_style = 0;
		hold_served = 0;
		llr_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_req) begin
				hold_served++;
				llr_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			if ($urandom_range(0, 63) == 0)
				rx_style = $urandom_range(0, 2);
			case (rx_style)
				0: llr_ch.ready <= 1'b1;
				1: llr_ch.ready <= 1'($urandom_range(0, 1));
				default: llr_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// compare received words in order
	always @(posedge clk) begin
		rx_word_t w;
		if (llr_ch.valid && llr_ch.ready) begin
			if (rx_expected.size() == 0) begin
				$error("unexpected word: bit_out %0b llr %0d last_out %0b",
					llr_ch.bit_out, llr_ch.llr, llr_ch.last_out);
				err_cnt++;
			end else begin
				w = rx_expected.pop_front();
				if (llr_ch.bit_out !== w.bit_out) begin
					$error("bit_out: expected %0b, got %0b", w.bit_out, llr_ch.bit_out);
					err_cnt++;
				end
				if (llr_ch.llr !== w.llr) begin
					$error("llr: expected %0d, got %0d", w.llr, llr_ch.llr);
					err_cnt++;
				end
				if (llr_ch.last_out !== w.last_out) begin
					$error("last_out: expected %0b, got %0b", w.last_out, llr_ch.last_out);
					err_cnt++;
				end
			end
		end
	end

	// run limit
	initial begin
		#48_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: bsc_awgn_channel_emulator_unit.f
sv/bac_pkg.sv
sv/bac_ifs.sv
sv/bac_ctrl.sv
sv/bac_dp.sv
sv/bsc_awgn_channel_emulator_unit.sv
tb/sv/bac_tb_ifs.sv
tb/sv/bsc_awgn_channel_emulator_unit_tb.sv
